FILE: rtl/rxs_pkg.sv
// shared types for the record exchange sort block
// state encoding and the command/status groups between controller and datapath
// no dependencies
`default_nettype none

package rxs_pkg;

   // width of the record count register
   localparam int unsigned COUNT_BITS = 5;
   // record count after reset
   localparam logic [COUNT_BITS-1:0] RECORD_COUNT_RESET = 5'd16;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_RD_I,
      ST_LD_I,
      ST_RD_J,
      ST_CMP,
      ST_WR_I,
      ST_EM_RD,
      ST_EM_LD
   } state_type;

   typedef struct packed {
      logic load_wr;
      logic rd_i;
      logic ld_i;
      logic rd_j;
      logic cmp;
      logic wr_i;
      logic em_rd;
      logic em_ld;
   } cmd_type;

   typedef struct packed {
      logic load_done;
      logic n_one;
      logic j_last;
      logic i_next_last;
      logic k_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/rxs_ctrl.sv
// sequencer for load, exchange sort and emit phases
// depends on rxs_pkg for the state, command and status types
`default_nettype none

module rxs_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire rxs_pkg::status_type sts,
   output rxs_pkg::cmd_type         cmd
);
   import rxs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && sts.load_done) state_in = ST_START;
         end
         ST_START: begin
            state_in = sts.n_one ? ST_EM_RD : ST_RD_I;
         end
         ST_RD_I:  state_in = ST_LD_I;
         ST_LD_I:  state_in = ST_RD_J;
         ST_RD_J:  state_in = ST_CMP;
         ST_CMP: begin
            state_in = sts.j_last ? ST_WR_I : ST_RD_J;
         end
         ST_WR_I: begin
            state_in = sts.i_next_last ? ST_EM_RD : ST_RD_I;
         end
         ST_EM_RD: begin
            if (sts.out_free) state_in = ST_EM_LD;
         end
         ST_EM_LD: begin
            state_in = sts.k_last ? ST_LOAD : ST_EM_RD;
         end
         default:  state_in = ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready   = 1'b1;
            cmd.load_wr = req_valid;
         end
         ST_RD_I:  cmd.rd_i  = 1'b1;
         ST_LD_I:  cmd.ld_i  = 1'b1;
         ST_RD_J:  cmd.rd_j  = 1'b1;
         ST_CMP:   cmd.cmp   = 1'b1;
         ST_WR_I:  cmd.wr_i  = 1'b1;
         ST_EM_RD: cmd.em_rd = sts.out_free;
         ST_EM_LD: cmd.em_ld = 1'b1;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/rxs_datapath.sv
// record store, index counters, compare-swap holder and output register
// depends on rxs_pkg for the command and status types
`default_nettype none

module rxs_datapath #(
   parameter int unsigned MAX_RECORDS = 16,
   parameter int unsigned KEY_BITS    = 16,
   parameter int unsigned TAG_BITS    = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire rxs_pkg::cmd_type               cmd,
   output rxs_pkg::status_type                 sts,
   input  wire signed [KEY_BITS-1:0]           req_year_key,
   input  wire        [TAG_BITS-1:0]           req_record_tag,
   input  wire                                 csr_valid,
   input  wire        [rxs_pkg::COUNT_BITS-1:0] csr_record_count,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [KEY_BITS-1:0]          rsp_sorted_year,
   output logic        [TAG_BITS-1:0]          rsp_sorted_tag,
   output logic                                rsp_last_record
);
   import rxs_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_RECORDS);
   localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
   localparam int unsigned CMP_W = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;
   localparam int unsigned REC_W = KEY_BITS + TAG_BITS;

   // key in the upper bits, tag in the lower bits
   logic [REC_W-1:0] mem [MAX_RECORDS];
   logic [REC_W-1:0] rdata_ff;

   logic [COUNT_BITS-1:0] count_ff;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [IDX_W-1:0]      i_ff, i_in;
   logic [IDX_W-1:0]      j_ff, j_in;
   logic [IDX_W-1:0]      k_ff, k_in;
   logic [REC_W-1:0]      cur_ff, cur_in;
   logic                  out_valid_ff, out_valid_in;
   logic [REC_W-1:0]      out_ff;
   logic                  out_last_ff;

   logic [CNT_W-1:0] fill_plus;
   logic [CMP_W-1:0] count_ext;
   logic [CNT_W-1:0] run_len;
   logic [IDX_W-1:0] nm1;
   logic             swap;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [REC_W-1:0] wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;

   // run length: zero acts as one, clamp at capacity
   always_comb begin
      count_ext = CMP_W'(count_ff);
      if (count_ext == '0) begin
         run_len = CNT_W'(1);
      end else if (count_ext > CMP_W'(MAX_RECORDS)) begin
         run_len = CNT_W'(MAX_RECORDS);
      end else begin
         run_len = CNT_W'(count_ext);
      end
   end

   assign fill_plus = fill_ff + CNT_W'(1);
   assign nm1       = IDX_W'(n_ff - CNT_W'(1));
   assign swap      = $signed(cur_ff[REC_W-1 -: KEY_BITS]) >
                      $signed(rdata_ff[REC_W-1 -: KEY_BITS]);

   assign sts.load_done   = fill_plus >= run_len;
   assign sts.n_one       = n_ff == CNT_W'(1);
   assign sts.j_last      = j_ff == nm1;
   assign sts.i_next_last = (i_ff + IDX_W'(1)) == nm1;
   assign sts.k_last      = k_ff == nm1;
   assign sts.out_free    = !out_valid_ff || rsp_ready;

   // memory port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = i_ff;
      wr_data = cur_ff;
      if (cmd.load_wr) begin
         wr_en   = 1'b1;
         wr_addr = fill_ff[IDX_W-1:0];
         wr_data = {req_year_key, req_record_tag};
      end else if (cmd.cmp) begin
         wr_en   = swap;
         wr_addr = j_ff;
      end else if (cmd.wr_i) begin
         wr_en   = 1'b1;
      end
      rd_en   = cmd.rd_i || cmd.rd_j || cmd.em_rd;
      rd_addr = cmd.rd_j ? j_ff : (cmd.em_rd ? k_ff : i_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   // counters and compare-swap holder
   always_comb begin
      fill_in      = fill_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.load_wr) begin
         if (sts.load_done) begin
            fill_in = '0;
            n_in    = fill_plus;
            i_in    = '0;
            k_in    = '0;
         end else begin
            fill_in = fill_plus;
         end
      end
      if (cmd.ld_i) begin
         cur_in = rdata_ff;
         j_in   = i_ff + IDX_W'(1);
      end
      if (cmd.cmp) begin
         if (swap) cur_in = rdata_ff;
         j_in = j_ff + IDX_W'(1);
      end
      if (cmd.wr_i) i_in = i_ff + IDX_W'(1);
      if (cmd.em_ld) begin
         out_valid_in = 1'b1;
         k_in         = k_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= RECORD_COUNT_RESET;
         fill_ff      <= '0;
         n_ff         <= CNT_W'(1);
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) count_ff <= csr_record_count;
         fill_ff      <= fill_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.em_ld) begin
         out_ff      <= rdata_ff;
         out_last_ff <= sts.k_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_sorted_year = out_ff[REC_W-1 -: KEY_BITS];
   assign rsp_sorted_tag  = out_ff[TAG_BITS-1:0];
   assign rsp_last_record = out_last_ff;

`ifndef SYNTHESIS
   // the fill index never reaches capacity between runs
   a_fill_below_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff < CNT_W'(MAX_RECORDS))
      else $error("fill count reached capacity");

   // a new result is only loaded when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.em_ld |-> $past(sts.out_free))
      else $error("output register overwritten");

   // every compare pairs a later entry with the held one
   a_j_after_i: assert property (@(posedge clock) disable iff (reset)
      cmd.cmp |-> (j_ff > i_ff) && (j_ff <= nm1))
      else $error("compare index out of order");

   // a run never holds more than capacity
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      (n_ff != '0) && (n_ff <= CNT_W'(MAX_RECORDS)))
      else $error("run length out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/record_exchange_sort_by_key_top.sv
// top level of the record exchange sort block
// instantiates rxs_ctrl and rxs_datapath, uses rxs_pkg
`default_nettype none

// usage
//   req channel: one record (signed year key, tag) per transfer; records are
//   stored until the configured record count has arrived
//   csr channel: writes the record count; zero acts as one, values above
//   MAX_RECORDS act as MAX_RECORDS; write only while the block is idle
//   rsp channel: after the run is complete the records come out ascending by
//   key, ties in exchange sort order, last_record set on the final one
// phases of a run
//   loading accepts one record per cycle; req_ready is high only while loading
//   sorting uses one memory read port and one write port with a held
//   candidate for position i
//   emitting moves each record through a registered memory read and then
//   into the output register
// reset clears the fill count, sets the record count to 16 and empties the
// output register; the record memory is not cleared
// when the receiver stalls the output register holds its record and the
// sequencer waits; loading of the next run starts while the final record
// still waits to be taken
module record_exchange_sort_by_key_top #(
   parameter int unsigned MAX_RECORDS = 16,
   parameter int unsigned KEY_BITS    = 16,
   parameter int unsigned TAG_BITS    = 8
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // input records
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire signed [KEY_BITS-1:0]            req_year_key,
   input  wire        [TAG_BITS-1:0]            req_record_tag,
   // sorted records
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic signed [KEY_BITS-1:0]           rsp_sorted_year,
   output logic        [TAG_BITS-1:0]           rsp_sorted_tag,
   output logic                                 rsp_last_record,
   // record count register
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire        [rxs_pkg::COUNT_BITS-1:0] csr_record_count
);
   import rxs_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencer: load, sort passes, emit
   rxs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // record memory, counters and output register
   rxs_datapath #(
      .MAX_RECORDS (MAX_RECORDS),
      .KEY_BITS    (KEY_BITS),
      .TAG_BITS    (TAG_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_year_key     (req_year_key),
      .req_record_tag   (req_record_tag),
      .csr_valid        (csr_valid),
      .csr_record_count (csr_record_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_year  (rsp_sorted_year),
      .rsp_sorted_tag   (rsp_sorted_tag),
      .rsp_last_record  (rsp_last_record)
   );

endmodule

`default_nettype wire

FILE: tb/record_exchange_sort_by_key_top_test.sv
`timescale 1ns / 100ps
// self-checking testbench for record_exchange_sort_by_key_top: loads record runs,
// predicts the exchange-sorted output and checks every sorted record field by field
// depends on rxs_pkg and the rtl of record_exchange_sort_by_key_top

module record_exchange_sort_by_key_top_test;
   import rxs_pkg::*;

   localparam int unsigned MAX_RECORDS = 16;
   localparam int unsigned KEY_BITS    = 16;
   localparam int unsigned TAG_BITS    = 8;
   localparam int CLOCK_PERIOD   = 10;
   // cycles without any transfer before the run is declared hung; stalls and
   // pauses stay well below this
   localparam int WATCHDOG_LIMIT = 5000;
   // quiet time around count writes and at the end, above one full sort pass
   localparam int SETTLE_CYCLES  = 400;

   typedef logic signed [KEY_BITS-1:0] year_type;
   typedef logic        [TAG_BITS-1:0] tag_type;
   typedef logic      [COUNT_BITS-1:0] count_type;

   typedef struct {
      year_type year;
      tag_type  tag;
      logic     last;
   } sorted_record_type;

   // block ports, all inputs known from time zero
   logic      clock            = 1'b0;
   logic      reset            = 1'b1;
   logic      req_valid        = 1'b0;
   year_type  req_year_key     = '0;
   tag_type   req_record_tag   = '0;
   logic      rsp_ready        = 1'b0;
   logic      csr_valid        = 1'b0;
   count_type csr_record_count = RECORD_COUNT_RESET;
   wire   req_ready;
   wire   rsp_valid;
   wire   signed [KEY_BITS-1:0] rsp_sorted_year;
   wire   [TAG_BITS-1:0] rsp_sorted_tag;
   wire   rsp_last_record;
   wire   csr_ready;

   // sorter model state: records held for the current run and the count register
   year_type    held_years [MAX_RECORDS];
   tag_type     held_tags  [MAX_RECORDS];
   int unsigned held_count       = 0;
   count_type   record_count_reg = RECORD_COUNT_RESET;

   // sorted records still owed by the block, oldest first
   sorted_record_type expected_sorted [$];

   int error_count     = 0;
   int records_sent    = 0;
   int records_checked = 0;
   int count_writes    = 0;
   int idle_cycles     = 0;
   // per-cycle idle odds in percent for each side; the directed tests start
   // with a bursty sender and a slow receiver
   int send_idle_pct   = 27;
   int recv_idle_pct   = 74;

   record_exchange_sort_by_key_top #(
      .MAX_RECORDS (MAX_RECORDS),
      .KEY_BITS    (KEY_BITS),
      .TAG_BITS    (TAG_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_year_key     (req_year_key),
      .req_record_tag   (req_record_tag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_year  (rsp_sorted_year),
      .rsp_sorted_tag   (rsp_sorted_tag),
      .rsp_last_record  (rsp_last_record),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_record_count (csr_record_count)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // effective run length: zero acts as one, anything above capacity as capacity
   function automatic int unsigned records_per_run(input count_type value);
      if (value == 0)
         return 1;
      if (value > MAX_RECORDS)
         return MAX_RECORDS;
      return value;
   endfunction

   // store one record; when the run is complete, exchange-sort the held records
   // and queue them as the expected output, last one flagged
   function automatic int predict_record(input year_type year, input tag_type tag);
      int unsigned n;
      year_type swap_year;
      tag_type swap_tag;
      sorted_record_type rec;
      if (held_count >= MAX_RECORDS)
         held_count = 0;
      held_years[held_count] = year;
      held_tags[held_count]  = tag;
      held_count++;
      // a count lowered to or below the fill completes the run with all held
      if (held_count < records_per_run(record_count_reg))
         return 0;
      n = held_count;
      // same swap sequence as the hardware, so ties land in the same order
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            if (held_years[i] > held_years[j]) begin
               swap_year     = held_years[i];
               swap_tag      = held_tags[i];
               held_years[i] = held_years[j];
               held_tags[i]  = held_tags[j];
               held_years[j] = swap_year;
               held_tags[j]  = swap_tag;
            end
         end
      end
      for (int k = 0; k < n; k++) begin
         rec.year = held_years[k];
         rec.tag  = held_tags[k];
         rec.last = (k == n - 1);
         expected_sorted.push_back(rec);
      end
      held_count = 0;
      return n;
   endfunction

   // random key: mostly full range, often a narrow band of years to force ties
   function automatic year_type random_year();
      if ($urandom_range(2) == 0)
         return year_type'($urandom_range(1995, 1999));
      return year_type'($urandom);
   endfunction

   // one record transfer, with a random idle gap ahead of it
   task automatic send_record(input year_type year, input tag_type tag);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_year_key   <= year;
      req_record_tag <= tag;
      do @(posedge clock); while (req_ready !== 1'b1);
      void'(predict_record(year, tag));
      records_sent++;
   endtask

   // hold off until every owed sorted record has come back
   task automatic wait_drained();
      do @(posedge clock); while (expected_sorted.size() != 0);
   endtask

   // count writes only with the sorter idle: drained, then a full sort time of quiet
   task automatic write_record_count(input count_type value);
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid        <= 1'b1;
      csr_record_count <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid        <= 1'b0;
      record_count_reg = value;
      count_writes++;
   endtask

   // complete runs of random records at one count setting; optionally the sender
   // waits for every sorted record after each run
   task automatic random_run_set(input count_type value, input int runs,
                                 input bit drain_each_run);
      int unsigned per_run;
      per_run = records_per_run(value);
      write_record_count(value);
      for (int r = 0; r < runs; r++) begin
         for (int k = 0; k < per_run; k++)
            send_record(random_year(), tag_type'($urandom_range(255)));
         if (drain_each_run || $urandom_range(7) == 0) begin
            req_valid <= 1'b0;
            wait_drained();
         end
      end
      req_valid <= 1'b0;
      wait_drained();
   endtask

   // full run at the reset count of 16: key and tag extremes, ties
   task automatic test_default_count();
      int years [16] = '{32767, -32768, 0, -1, 100, 1, 100, -32768,
                         32767, 2024, -5, 0, 1999, 100, -1, 7};
      int tags  [16] = '{0, 255, 1, 128, 10, 20, 30, 40,
                         50, 60, 70, 80, 90, 100, 254, 127};
      for (int i = 0; i < 16; i++)
         send_record(year_type'(years[i]), tag_type'(tags[i]));
      req_valid <= 1'b0;
      wait_drained();
   endtask

   // count zero behaves as one, then count one proper: every record is its own run
   task automatic test_count_edges();
      write_record_count(count_type'(0));
      send_record(year_type'(32767), tag_type'(255));
      send_record(year_type'(-32768), tag_type'(0));
      write_record_count(count_type'(1));
      send_record(year_type'(-1), tag_type'(170));
      req_valid <= 1'b0;
      wait_drained();
   endtask

   // count above capacity holds three records without sorting, then the count
   // drops below the fill and the next record closes a run of four
   task automatic test_count_lowered_mid_run();
      write_record_count(count_type'(31));
      send_record(year_type'(500), tag_type'(1));
      send_record(year_type'(-500), tag_type'(2));
      send_record(year_type'(500), tag_type'(3));
      write_record_count(count_type'(2));
      send_record(year_type'(0), tag_type'(4));
      req_valid <= 1'b0;
      wait_drained();
   endtask

   // bursty sender, heavily stalled receiver, maximum count setting
   task automatic test_slow_receiver();
      send_idle_pct = 27;
      recv_idle_pct = 74;
      random_run_set(count_type'(31), 3, 1'b0);
   endtask

   // heavily idle sender, light receiver stalls, a new count for every run set
   task automatic test_slow_sender();
      int target;
      send_idle_pct = 74;
      recv_idle_pct = 27;
      target = records_sent + 60;
      while (records_sent < target)
         random_run_set(count_type'($urandom_range(0, 31)), 1 + $urandom_range(1), 1'b0);
   endtask

   // no idling on either side; loading overlaps the final output, and the second
   // set waits for the whole sorted output after each run
   task automatic test_full_rate();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_run_set(count_type'(5), 8, 1'b0);
      random_run_set(count_type'(12), 3, 1'b1);
   endtask

   // receiver readiness, redrawn each cycle
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // sorted record checker, values sampled as they stood before the edge
   always @(posedge clock) begin
      sorted_record_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         records_checked++;
         if (expected_sorted.size() == 0) begin
            error_count++;
            $error("unexpected sorted record: year %0d tag %0d last %0b",
                   rsp_sorted_year, rsp_sorted_tag, rsp_last_record);
         end else begin
            want = expected_sorted.pop_front();
            if (rsp_sorted_year !== want.year) begin
               error_count++;
               $error("sorted_year mismatch: expected %0d, actual %0d",
                      want.year, rsp_sorted_year);
            end
            if (rsp_sorted_tag !== want.tag) begin
               error_count++;
               $error("sorted_tag mismatch: expected %0d, actual %0d",
                      want.tag, rsp_sorted_tag);
            end
            if (rsp_last_record !== want.last) begin
               error_count++;
               $error("last_record mismatch: expected %0b, actual %0b",
                      want.last, rsp_last_record);
            end
         end
      end
   end

   // watchdog: any transfer on any channel restarts the count
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_count();
      test_count_edges();
      test_count_lowered_mid_run();
      test_slow_receiver();
      test_slow_sender();
      test_full_rate();

      // nothing owed any more; leave room for stray output before closing
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d records, checked %0d sorted records, %0d record-count writes",
               records_sent, records_checked, count_writes);
      $display("covered key extremes, ties, counts 0 to 31, a count lowered mid-run, stalls");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
rtl/rxs_pkg.sv
rtl/rxs_ctrl.sv
rtl/rxs_datapath.sv
rtl/record_exchange_sort_by_key_top.sv
tb/record_exchange_sort_by_key_top_test.sv
